[rtl/dbtd_pkg.sv]
// ----------------------------------------------------------------------------
// dbtd_pkg
// Shared types and constants of the dark border trim detector.
// ----------------------------------------------------------------------------
package dbtd_pkg;

  localparam int PIX_W       = 8;
  localparam int IN_TDATA_W  = 24;
  localparam int TRIM_W      = 12;
  localparam int SIZE_W      = 13;
  localparam int OUT_TDATA_W = 104;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;
  localparam int THR_W       = 8;
  localparam int MIN_W       = 3;
  localparam int LUMA_W      = 18;
  localparam int CNT_W       = 3;

  localparam int LUMA_R      = 299;
  localparam int LUMA_G      = 587;
  localparam int LUMA_B      = 114;
  localparam int LUMA_SCALE  = 1000;

  localparam int RST_THRESH  = 42;
  localparam int RST_MIN     = 3;
  localparam int MIN_FRAME   = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH       = 2'd0,
    REG_HEIGHT      = 2'd1,
    REG_THRESH      = 2'd2,
    REG_MIN_SAMPLES = 2'd3
  } cfg_reg_t;

endpackage

[rtl/dark_border_trim_detector.sv]
// ----------------------------------------------------------------------------
// dark_border_trim_detector
// Finds dark border rows and columns of a raster RGB frame and reports the
// trims and the crop rectangle once per frame.
// ----------------------------------------------------------------------------
// Result path: a frame's last pixel goes through stage 1 and stage 2 into the output register.
// Throughput: one pixel per clock; the last pixel of a frame waits while an
//   earlier frame's result is still in flight or not yet taken.
// Column counts: one 3-bit read-modify-write per pixel on a store with one read
//   and one write port.
// Reset: config to defaults, frame position to zero; the column store is not
//   swept, a fill mark makes never-written columns read as zero.
module dark_border_trim_detector #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // config write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dbtd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dbtd_pkg::CFG_DATA_W-1:0]    cfg_data,
  // pixel input
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [dbtd_pkg::IN_TDATA_W-1:0]    in_tdata,   // red[7:0], green[15:8], blue[23:16]
  // result output
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [dbtd_pkg::OUT_TDATA_W-1:0]   out_tdata,  // left_trim[11:0], top_trim[23:12],
                                                         // right_trim[35:24], bottom_trim[47:36],
                                                         // crop_x[59:48], crop_y[71:60],
                                                         // crop_width[84:72], crop_height[97:85]
  output logic                               out_tuser   // trimmed[0]
);

  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int YW   = $clog2(MAX_HEIGHT);
  localparam int RWW  = $clog2(MAX_WIDTH / 2 + 1);
  localparam int RHW  = $clog2(MAX_HEIGHT / 2 + 1);
  localparam int WN   = WW + 1;
  localparam int HN   = HW + 1;
  localparam int WMAG = (2 ** (WN + 1) + 2) / 3;
  localparam int HMAG = (2 ** (HN + 1) + 2) / 3;
  localparam int RST_W = (MAX_WIDTH < 4096) ? MAX_WIDTH : 4096;
  localparam int RST_H = (MAX_HEIGHT < 4096) ? MAX_HEIGHT : 4096;
  localparam int TW   = dbtd_pkg::TRIM_W;
  localparam int SW   = dbtd_pkg::SIZE_W;
  localparam int PW   = dbtd_pkg::PIX_W;
  localparam int LW   = dbtd_pkg::LUMA_W;
  localparam int CW   = dbtd_pkg::CNT_W;
  localparam int MW   = dbtd_pkg::MIN_W;
  localparam int OW   = dbtd_pkg::OUT_TDATA_W;

  // ---------------- configuration ----------------
  logic [WW-1:0] w_r, w3_r, w23_r;
  logic [HW-1:0] h_r, h3_r, h23_r;
  logic [LW-1:0] thr_lim_r;
  logic [MW-1:0] min_r;

  logic [WW-1:0]     w_cl;
  logic [HW-1:0]     h_cl;
  logic [2*WN-1:0]   w_p1, w_p2;
  logic [2*HN-1:0]   h_p1, h_p2;
  logic [LW-1:0]     thr_lim_nxt;
  logic              cfg_acc;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;

  always_comb begin
    int wv;
    int hv;
    wv = int'(cfg_data);
    hv = int'(cfg_data);
    if (wv < 1) wv = 1;
    if (wv > MAX_WIDTH) wv = MAX_WIDTH;
    if (hv < 1) hv = 1;
    if (hv > MAX_HEIGHT) hv = MAX_HEIGHT;
    w_cl = WW'(wv);
    h_cl = HW'(hv);
    w_p1 = (2*WN)'(w_cl) * (2*WN)'(WMAG);
    w_p2 = (2*WN)'({w_cl, 1'b0}) * (2*WN)'(WMAG);
    h_p1 = (2*HN)'(h_cl) * (2*HN)'(HMAG);
    h_p2 = (2*HN)'({h_cl, 1'b0}) * (2*HN)'(HMAG);
    thr_lim_nxt = (LW'(cfg_data[dbtd_pkg::THR_W-1:0]) + LW'(1)) * LW'(dbtd_pkg::LUMA_SCALE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r       <= WW'(RST_W);
      w3_r      <= WW'(RST_W / 3);
      w23_r     <= WW'((2 * RST_W) / 3);
      h_r       <= HW'(RST_H);
      h3_r      <= HW'(RST_H / 3);
      h23_r     <= HW'((2 * RST_H) / 3);
      thr_lim_r <= LW'((dbtd_pkg::RST_THRESH + 1) * dbtd_pkg::LUMA_SCALE);
      min_r     <= MW'(dbtd_pkg::RST_MIN);
    end else if (cfg_acc) begin
      unique case (dbtd_pkg::cfg_reg_t'(cfg_index))
        dbtd_pkg::REG_WIDTH: begin
          w_r   <= w_cl;
          w3_r  <= WW'(w_p1 >> (WN + 1));
          w23_r <= WW'(w_p2 >> (WN + 1));
        end
        dbtd_pkg::REG_HEIGHT: begin
          h_r   <= h_cl;
          h3_r  <= HW'(h_p1 >> (HN + 1));
          h23_r <= HW'(h_p2 >> (HN + 1));
        end
        dbtd_pkg::REG_THRESH:      thr_lim_r <= thr_lim_nxt;
        dbtd_pkg::REG_MIN_SAMPLES: min_r <= cfg_data[MW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- stage 0: accept, position, luma ----------------
  logic [XW-1:0] col_pos_r;
  logic [YW-1:0] row_pos_r;
  logic [WW-1:0] col_w;
  logic [HW-1:0] row_h;
  logic          last_col0, last_row0, dark0, in_acc;
  logic [CW-1:0] col_hits0, row_hits0;
  logic [LW-1:0] luma0;
  logic [PW-1:0] red, green, blue;

  // pipeline/result state used by the accept gate
  logic          s1_valid_r, s1_lc_r, s1_lr_r, s1_end;
  logic          s2_valid_r;
  logic          out_valid_r;

  assign red   = in_tdata[PW-1:0];
  assign green = in_tdata[2*PW-1:PW];
  assign blue  = in_tdata[3*PW-1:2*PW];

  assign col_w     = WW'(col_pos_r);
  assign row_h     = HW'(row_pos_r);
  assign last_col0 = col_w >= (w_r - WW'(1));
  assign last_row0 = row_h >= (h_r - HW'(1));

  assign luma0 = LW'(red) * LW'(dbtd_pkg::LUMA_R) + LW'(green) * LW'(dbtd_pkg::LUMA_G)
               + LW'(blue) * LW'(dbtd_pkg::LUMA_B);
  assign dark0 = luma0 < thr_lim_r;

  assign col_hits0 = CW'(col_w == '0) + CW'(col_w == w3_r) + CW'(col_w == w23_r)
                   + CW'(col_w == (w_r - WW'(1)));
  assign row_hits0 = CW'(row_h == '0) + CW'(row_h == h3_r) + CW'(row_h == h23_r)
                   + CW'(row_h == (h_r - HW'(1)));

  assign s1_end    = s1_valid_r && s1_lc_r && s1_lr_r;
  assign in_tready = !(last_col0 && last_row0
                       && (s1_end || s2_valid_r || (out_valid_r && !out_tready)));
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r <= '0;
      row_pos_r <= '0;
    end else if (in_acc) begin
      if (last_col0) begin
        col_pos_r <= '0;
        row_pos_r <= last_row0 ? '0 : row_pos_r + YW'(1);
      end else begin
        col_pos_r <= col_pos_r + XW'(1);
      end
    end
  end

  // ---------------- column count store ----------------
  logic [CW-1:0] cnt_mem [MAX_WIDTH];
  logic [CW-1:0] mem_q_r;
  logic [WW-1:0] fill_r;
  logic [XW-1:0] s1_x_r;
  logic          s1_row0_r, s1_rd_ok_r, s1_fwd_r;
  logic [CW-1:0] s1_chits_r, s1_rhits_r, fwd_val_r;
  logic [CW-1:0] ccount;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mem_q_r <= cnt_mem[col_pos_r];
    end
    if (s1_valid_r) begin
      cnt_mem[s1_x_r] <= ccount;
    end
  end

  // ---------------- stage 1: count update, run tracking ----------------
  logic [CW-1:0]  base1, rsum;
  logic [CW:0]    csum, rsum_w;
  logic           cborder, rborder;
  logic [RWW-1:0] wcap, wh;
  logic [RHW-1:0] hcap, hh;
  logic [RWW-1:0] left_r, right_r, left_nxt, right_nxt;
  logic [RHW-1:0] top_r, bottom_r, top_nxt, bottom_nxt;
  logic           left_open_r, top_open_r, left_open_nxt, top_open_nxt;
  logic [CW-1:0]  row_cnt_r;

  always_comb begin
    if (s1_row0_r)       base1 = '0;
    else if (s1_fwd_r)   base1 = fwd_val_r;
    else if (s1_rd_ok_r) base1 = mem_q_r;
    else                 base1 = '0;
    csum   = (CW+1)'(base1) + (CW+1)'(s1_rhits_r);
    ccount = csum[CW] ? '1 : csum[CW-1:0];
    rsum_w = (CW+1)'(row_cnt_r) + (CW+1)'(s1_chits_r);
    rsum   = rsum_w[CW] ? '1 : rsum_w[CW-1:0];
    cborder = ccount >= CW'(min_r);
    rborder = rsum >= CW'(min_r);

    wh   = RWW'(w_r >> 1);
    wcap = (wh == '0) ? RWW'(1) : wh;
    hh   = RHW'(h_r >> 1);
    hcap = (hh == '0) ? RHW'(1) : hh;

    left_nxt      = left_r;
    left_open_nxt = left_open_r;
    right_nxt     = right_r;
    if (s1_lr_r) begin
      if (left_open_r) begin
        if (!cborder)            left_open_nxt = 1'b0;
        else if (left_r < wcap)  left_nxt = left_r + RWW'(1);
      end
      right_nxt = cborder ? ((right_r < wcap) ? right_r + RWW'(1) : wcap) : '0;
    end

    top_nxt      = top_r;
    top_open_nxt = top_open_r;
    bottom_nxt   = bottom_r;
    if (s1_lc_r) begin
      if (top_open_r) begin
        if (!rborder)          top_open_nxt = 1'b0;
        else if (top_r < hcap) top_nxt = top_r + RHW'(1);
      end
      bottom_nxt = rborder ? ((bottom_r < hcap) ? bottom_r + RHW'(1) : hcap) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fill_r      <= '0;
      row_cnt_r   <= '0;
      left_r      <= '0;
      right_r     <= '0;
      top_r       <= '0;
      bottom_r    <= '0;
      left_open_r <= 1'b1;
      top_open_r  <= 1'b1;
      s2_valid_r  <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
      s2_valid_r <= s1_end;
      if (s1_valid_r) begin
        if (WW'(s1_x_r) >= fill_r) fill_r <= WW'(s1_x_r) + WW'(1);
        row_cnt_r <= s1_lc_r ? '0 : rsum;
        if (s1_end) begin
          left_r      <= '0;
          right_r     <= '0;
          top_r       <= '0;
          bottom_r    <= '0;
          left_open_r <= 1'b1;
          top_open_r  <= 1'b1;
        end else begin
          left_r      <= left_nxt;
          right_r     <= right_nxt;
          top_r       <= top_nxt;
          bottom_r    <= bottom_nxt;
          left_open_r <= left_open_nxt;
          top_open_r  <= top_open_nxt;
        end
      end
    end
  end

  // stage 1 and stage 2 payload
  logic [RWW-1:0] s2_l_r, s2_rt_r;
  logic [RHW-1:0] s2_t_r, s2_bt_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_x_r     <= col_pos_r;
      s1_lc_r    <= last_col0;
      s1_lr_r    <= last_row0;
      s1_row0_r  <= (row_pos_r == '0);
      s1_chits_r <= dark0 ? col_hits0 : '0;
      s1_rhits_r <= dark0 ? row_hits0 : '0;
      s1_rd_ok_r <= col_w < fill_r;
      s1_fwd_r   <= s1_valid_r && (s1_x_r == col_pos_r);
      fwd_val_r  <= ccount;
    end
    if (s1_end) begin
      s2_l_r  <= left_nxt;
      s2_rt_r <= right_nxt;
      s2_t_r  <= top_nxt;
      s2_bt_r <= bottom_nxt;
    end
  end

  // ---------------- stage 2: crop rectangle ----------------
  logic [WW:0]   lr_sum;
  logic [HW:0]   tb_sum;
  logic [WW-1:0] cw_raw, cw2;
  logic [HW-1:0] ch_raw, ch2;
  logic          ok2;

  always_comb begin
    lr_sum = (WW+1)'(s2_l_r) + (WW+1)'(s2_rt_r);
    tb_sum = (HW+1)'(s2_t_r) + (HW+1)'(s2_bt_r);
    cw_raw = ((WW+1)'(w_r) > lr_sum) ? WW'((WW+1)'(w_r) - lr_sum) : '0;
    ch_raw = ((HW+1)'(h_r) > tb_sum) ? HW'((HW+1)'(h_r) - tb_sum) : '0;
    cw2 = (cw_raw == '0) ? WW'(1) : cw_raw;
    ch2 = (ch_raw == '0) ? HW'(1) : ch_raw;
    ok2 = (w_r >= WW'(dbtd_pkg::MIN_FRAME)) && (h_r >= HW'(dbtd_pkg::MIN_FRAME))
       && !((s2_l_r == '0) && (s2_t_r == '0) && (s2_rt_r == '0) && (s2_bt_r == '0))
       && (cw2 > WW'(1)) && (ch2 > HW'(1));
  end

  // ---------------- output register ----------------
  logic          out_trim_r;
  logic [TW-1:0] out_l_r, out_t_r, out_rt_r, out_bt_r, out_x_r, out_y_r;
  logic [SW-1:0] out_cw_r, out_ch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_valid_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid_r) begin
      out_trim_r <= ok2;
      out_l_r    <= TW'(s2_l_r);
      out_t_r    <= TW'(s2_t_r);
      out_rt_r   <= TW'(s2_rt_r);
      out_bt_r   <= TW'(s2_bt_r);
      out_x_r    <= ok2 ? TW'(s2_l_r) : '0;
      out_y_r    <= ok2 ? TW'(s2_t_r) : '0;
      out_cw_r   <= ok2 ? SW'(cw2) : SW'(w_r);
      out_ch_r   <= ok2 ? SW'(ch2) : SW'(h_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_trim_r;
  assign out_tdata  = OW'({out_ch_r, out_cw_r, out_y_r, out_x_r,
                           out_bt_r, out_rt_r, out_t_r, out_l_r});

  // ---------------- assertions ----------------
  a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> (!out_valid_r || out_tready))
    else $error("frame result reached a full output register");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_end && s2_valid_r))
    else $error("two frame results in flight");

  a_fwd_src: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_fwd_r) |-> $past(s1_valid_r))
    else $error("count forwarded without a preceding write");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |=> (fill_r > WW'($past(s1_x_r))))
    else $error("fill mark behind a written column");

endmodule

[dv/tb_dark_border_trim_detector.sv]
// ----------------------------------------------------------------------------
// tb_dark_border_trim_detector
// Streams RGB frames with random dark borders into the detector. A local
// scoreboard tracks border rows and columns per pixel, queues the expected
// trims and crop per frame, and checks each output request field by field.
// ----------------------------------------------------------------------------
module tb_dark_border_trim_detector;

  localparam int MAXW      = 4096;
  localparam int MAXH      = 4096;
  localparam int LIMIT     = 500000;
  localparam int RAND_PX   = 1100;
  localparam int RAND_FRMS = 12;
  localparam int PW        = dbtd_pkg::PIX_W;

  typedef struct packed {
    logic [dbtd_pkg::PIX_W-1:0] b;
    logic [dbtd_pkg::PIX_W-1:0] g;
    logic [dbtd_pkg::PIX_W-1:0] r;
  } pixel_t;

  typedef struct {
    bit trimmed;
    int trim_l, trim_t, trim_r, trim_b;
    int crop_x, crop_y, crop_w, crop_h;
  } crop_t;

  logic                             clk = 0;
  logic                             rst_n = 0;
  logic                             cfg_valid = 0;
  logic                             cfg_ready;
  logic [dbtd_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [dbtd_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                             in_tvalid = 0;
  logic                             in_tready;
  logic [dbtd_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                             out_tvalid;
  logic                             out_tready = 0;
  logic [dbtd_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             out_tuser;

  dark_border_trim_detector dut (.*);

  always #10 clk = ~clk;

  // scoreboard copy of config and frame state
  int m_width, m_height, m_thresh, m_min;
  int col_hits [MAXW];
  int col_pos, row_pos, row_hits;
  int top_run, bot_run, left_run, right_run;
  bit top_open, left_open;

  pixel_t pixel_q [$];
  crop_t  pending_crops [$];
  int n_queued, n_taken, n_err, cycles;
  int gap_left, burst_left, rx_mode, rx_left, hold_left;
  bit px_taken;

  function automatic int tap_hits(int pos, int size);
    return int'(pos == 0) + int'(pos == size / 3) + int'(pos == (size * 2) / 3) +
           int'(pos == size - 1);
  endfunction

  function automatic int clamp_size(int v, int maxv);
    return (v < 1) ? 1 : (v > maxv) ? maxv : v;
  endfunction

  function automatic void new_frame();
    col_pos   = 0;
    row_pos   = 0;
    row_hits  = 0;
    top_run   = 0;
    top_open  = 1'b1;
    bot_run   = 0;
    left_run  = 0;
    left_open = 1'b1;
    right_run = 0;
  endfunction

  function automatic void track_pixel(pixel_t p);
    int  w, h, luma, cc, wcap, hcap, cw, ch;
    bit  dark, last_col, last_row, cb, rb, ok;
    crop_t e;
    w        = m_width;
    h        = m_height;
    luma     = dbtd_pkg::LUMA_R * int'(p.r) + dbtd_pkg::LUMA_G * int'(p.g) +
               dbtd_pkg::LUMA_B * int'(p.b);
    dark     = luma < (m_thresh + 1) * dbtd_pkg::LUMA_SCALE;
    last_col = col_pos >= w - 1;
    last_row = row_pos >= h - 1;
    wcap     = (w / 2 > 1) ? w / 2 : 1;
    hcap     = (h / 2 > 1) ? h / 2 : 1;
    if (dark) row_hits += tap_hits(col_pos, w);
    cc = (row_pos == 0) ? 0 : col_hits[col_pos];
    if (dark) cc += tap_hits(row_pos, h);
    if (cc > 7) cc = 7;
    col_hits[col_pos] = cc;
    if (last_row) begin
      cb = cc >= m_min;
      if (left_open) begin
        if (!cb) left_open = 1'b0;
        else if (left_run < wcap) left_run++;
      end
      right_run = cb ? ((right_run < wcap) ? right_run + 1 : wcap) : 0;
    end
    if (!last_col) begin
      col_pos++;
      return;
    end
    rb = row_hits >= m_min;
    if (top_open) begin
      if (!rb) top_open = 1'b0;
      else if (top_run < hcap) top_run++;
    end
    bot_run  = rb ? ((bot_run < hcap) ? bot_run + 1 : hcap) : 0;
    row_hits = 0;
    col_pos  = 0;
    if (!last_row) begin
      row_pos++;
      return;
    end
    cw = (w > left_run + right_run) ? w - left_run - right_run : 0;
    ch = (h > top_run + bot_run) ? h - top_run - bot_run : 0;
    if (cw < 1) cw = 1;
    if (ch < 1) ch = 1;
    ok = 1'b1;
    if (w < dbtd_pkg::MIN_FRAME || h < dbtd_pkg::MIN_FRAME) ok = 1'b0;
    if (left_run == 0 && top_run == 0 && right_run == 0 && bot_run == 0) ok = 1'b0;
    if (cw <= 1 || ch <= 1) ok = 1'b0;
    e.trimmed = ok;
    e.trim_l  = left_run;
    e.trim_t  = top_run;
    e.trim_r  = right_run;
    e.trim_b  = bot_run;
    e.crop_x  = ok ? left_run : 0;
    e.crop_y  = ok ? top_run : 0;
    e.crop_w  = ok ? cw : w;
    e.crop_h  = ok ? ch : h;
    pending_crops.push_back(e);
    new_frame();
  endfunction

  function automatic void cmp(string name, int exp_v, logic [31:0] act);
    if (act !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act);
      n_err++;
    end
  endfunction

  function automatic void check_crop();
    crop_t e;
    if (pending_crops.size() == 0) begin
      $error("result request with no frame pending");
      n_err++;
      return;
    end
    e = pending_crops.pop_front();
    cmp("trimmed",     int'(e.trimmed), 32'(out_tuser));
    cmp("left_trim",   e.trim_l,  32'(out_tdata[11:0]));
    cmp("top_trim",    e.trim_t,  32'(out_tdata[23:12]));
    cmp("right_trim",  e.trim_r,  32'(out_tdata[35:24]));
    cmp("bottom_trim", e.trim_b,  32'(out_tdata[47:36]));
    cmp("crop_x",      e.crop_x,  32'(out_tdata[59:48]));
    cmp("crop_y",      e.crop_y,  32'(out_tdata[71:60]));
    cmp("crop_width",  e.crop_w,  32'(out_tdata[84:72]));
    cmp("crop_height", e.crop_h,  32'(out_tdata[97:85]));
  endfunction

  // monitor
  always @(posedge clk) begin
    cycles++;
    px_taken = rst_n && in_tvalid && in_tready;
    if (rst_n && out_tvalid && out_tready) check_crop();
    if (px_taken) begin
      n_taken++;
      track_pixel(pixel_t'(in_tdata));
    end
    if (cycles > LIMIT) begin
      $display("** dark_border_trim_detector: FAILED **");
      $finish;
    end
  end

  // pixel driver: bursts with random gaps
  always @(negedge clk) begin
    if (!(in_tvalid && !px_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        in_tdata  <= pixel_q.pop_front();
        in_tvalid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 48);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(20, 200);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  task automatic write_reg(dbtd_pkg::cfg_reg_t idx, logic [dbtd_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      dbtd_pkg::REG_WIDTH:       m_width  = clamp_size(int'(val), MAXW);
      dbtd_pkg::REG_HEIGHT:      m_height = clamp_size(int'(val), MAXH);
      dbtd_pkg::REG_THRESH:      m_thresh = int'(val[dbtd_pkg::THR_W-1:0]);
      dbtd_pkg::REG_MIN_SAMPLES: m_min    = int'(val[dbtd_pkg::MIN_W-1:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (n_taken != n_queued || pending_crops.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic void push_px(pixel_t p);
    pixel_q.push_back(p);
    n_queued++;
  endfunction

  function automatic pixel_t dark_px();
    pixel_t p;
    p.r = PW'($urandom_range(m_thresh, 0));
    p.g = PW'($urandom_range(m_thresh, 0));
    p.b = PW'($urandom_range(m_thresh, 0));
    return p;
  endfunction

  function automatic pixel_t bright_px();
    pixel_t p;
    if (m_thresh >= 255) return pixel_t'(24'($urandom_range(0, 24'hFFFFFF)));
    p.r = PW'($urandom_range(255, m_thresh + 1));
    p.g = PW'($urandom_range(255, m_thresh + 1));
    p.b = PW'($urandom_range(255, m_thresh + 1));
    return p;
  endfunction

  // one whole frame with a random dark border and some noise
  function automatic void queue_frame();
    int w, h, bl, bt, br, bb;
    w  = m_width;
    h  = m_height;
    bl = $urandom_range(0, w / 2 + 1);
    br = $urandom_range(0, w / 2 + 1);
    bt = $urandom_range(0, h / 2 + 1);
    bb = $urandom_range(0, h / 2 + 1);
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++) begin
        if ($urandom_range(0, 9) == 0)
          push_px(pixel_t'(24'($urandom_range(0, 24'hFFFFFF))));
        else if (x < bl || x >= w - br || y < bt || y >= h - bb)
          push_px(dark_px());
        else
          push_px(bright_px());
      end
  endfunction

  function automatic int frame_left();
    int c, r;
    c = (col_pos >= m_width - 1) ? m_width - 1 : col_pos;
    r = (row_pos >= m_height - 1) ? m_height - 1 : row_pos;
    return (m_width - 1 - c) + 1 + (m_height - 1 - r) * m_width;
  endfunction

  function automatic int pick_size();
    int k;
    k = $urandom_range(0, 9);
    if (k < 7) return $urandom_range(1, 12);
    if (k < 9) return $urandom_range(13, 40);
    return $urandom_range(1, 3);
  endfunction

  initial begin
    int w, h, t, n, n_px, n_frm;
    bit squeezed;
    m_width  = MAXW;
    m_height = MAXH;
    m_thresh = dbtd_pkg::RST_THRESH;
    m_min    = dbtd_pkg::RST_MIN;
    for (int i = 0; i < MAXW; i++) col_hits[i] = 0;
    new_frame();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // 3x3 frame at reset threshold, channel extremes and the threshold edge
    write_reg(dbtd_pkg::REG_WIDTH, 13'd3);
    write_reg(dbtd_pkg::REG_HEIGHT, 13'd3);
    push_px('{8'd0, 8'd0, 8'd0});
    push_px('{8'd255, 8'd255, 8'd255});
    push_px('{8'd42, 8'd42, 8'd42});
    push_px('{8'd43, 8'd43, 8'd43});
    push_px('{8'd0, 8'd0, 8'd255});
    push_px('{8'd0, 8'd255, 8'd0});
    push_px('{8'd255, 8'd0, 8'd0});
    push_px('{8'd0, 8'd0, 8'd0});
    push_px('{8'd0, 8'd0, 8'd0});
    wait_idle();

    // zero width held as one: single-pixel frames
    write_reg(dbtd_pkg::REG_WIDTH, 13'd0);
    write_reg(dbtd_pkg::REG_HEIGHT, 13'd1);
    push_px('{8'd255, 8'd255, 8'd255});
    push_px('{8'd0, 8'd0, 8'd0});
    wait_idle();

    // shrink width and height in the middle of a frame
    write_reg(dbtd_pkg::REG_WIDTH, 13'd5);
    write_reg(dbtd_pkg::REG_HEIGHT, 13'd5);
    for (int i = 0; i < 13; i++) push_px(dark_px());
    wait_idle();
    write_reg(dbtd_pkg::REG_WIDTH, 13'd2);
    write_reg(dbtd_pkg::REG_HEIGHT, 13'd2);
    n = frame_left();
    for (int i = 0; i < n; i++) push_px(dark_px());
    wait_idle();

    // oversize width held at the maximum, then cut short by a narrower width
    write_reg(dbtd_pkg::REG_WIDTH, 13'h1FFF);
    write_reg(dbtd_pkg::REG_HEIGHT, 13'd1);
    write_reg(dbtd_pkg::REG_THRESH, 13'h1FFF);
    write_reg(dbtd_pkg::REG_MIN_SAMPLES, 13'd4);
    for (int i = 0; i < 40; i++) push_px(dark_px());
    wait_idle();
    write_reg(dbtd_pkg::REG_WIDTH, 13'd8);
    n = frame_left();
    for (int i = 0; i < n; i++) push_px(dark_px());
    wait_idle();

    n_px     = 0;
    n_frm    = 0;
    squeezed = 1'b0;
    while (n_px < RAND_PX || n_frm < RAND_FRMS) begin
      if (!squeezed && n_frm >= 4) begin
        // long output stall while small frames keep coming
        squeezed = 1'b1;
        write_reg(dbtd_pkg::REG_WIDTH, 13'd2);
        write_reg(dbtd_pkg::REG_HEIGHT, 13'd2);
        @(posedge clk);
        hold_left = 300;
        for (int i = 0; i < 8; i++) queue_frame();
        n_frm += 8;
        n_px  += 32;
        wait_idle();
      end
      w = pick_size();
      h = pick_size();
      if (w * h > 120) h = 120 / w;
      write_reg(dbtd_pkg::REG_WIDTH, (w == 1 && $urandom_range(0, 1)) ? 13'd0 : 13'(w));
      write_reg(dbtd_pkg::REG_HEIGHT, (h == 1 && $urandom_range(0, 1)) ? 13'd0 : 13'(h));
      case ($urandom_range(0, 7))
        0: t = 0;
        1: t = 255;
        default: t = $urandom_range(20, 120);
      endcase
      write_reg(dbtd_pkg::REG_THRESH, {5'($urandom_range(0, 31)), 8'(t)});
      write_reg(dbtd_pkg::REG_MIN_SAMPLES, ($urandom_range(0, 3) == 0) ?
                13'($urandom_range(0, 8191)) : 13'($urandom_range(1, 4)));
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) queue_frame();
      n_frm += n;
      n_px  += n * w * h;
      wait_idle();
    end

    wait_idle();
    if (n_err == 0)
      $display("** dark_border_trim_detector: PASSED **");
    else
      $display("** dark_border_trim_detector: FAILED **");
    $finish;
  end

endmodule
